/* hdl/gpn_pkg.sv */
`default_nettype none

package gpn_pkg;

  localparam logic [2:0] TYPE_UNKNOWN  = 3'd0;
  localparam logic [2:0] TYPE_WIRELESS = 3'd1;
  localparam logic [2:0] TYPE_WIRED    = 3'd2;
  localparam logic [2:0] TYPE_NEWER    = 3'd3;
  localparam logic [2:0] TYPE_ORIGINAL = 3'd4;

  localparam logic [7:0] HDR_REPORT       = 8'h14;
  localparam logic [7:0] HDR_WIRELESS_PAD = 8'h13;
  localparam logic [7:0] HDR_NEWER_INPUT  = 8'h20;
  localparam logic [7:0] HDR_NEWER_VKEY   = 8'h07;
  localparam logic [7:0] HDR_NEWER_HELLO  = 8'h02;
  localparam logic [7:0] VKEY_DOWN        = 8'h01;
  localparam logic [7:0] VKEY_UP          = 8'h00;

  localparam int WL_LINK_FLAG_BIT = 3;
  localparam int GUIDE_BIT        = 10;
  localparam int SHARE_BIT        = 11;

  localparam logic [15:0] WIRED_BTN_MASK    = 16'hF7FF;
  localparam logic [15:0] WIRELESS_BTN_MASK = 16'hF3FF;

  localparam logic [6:0] POS_MAX = 7'd127;

  typedef enum logic [0:0] {
    REG_CONTROLLER_TYPE = 1'b0,
    REG_THRESHOLD       = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [2:0] controller_type;
    logic [7:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        buttons;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic               connected;
    logic               updated;
    logic               reinit_request;
  } res_t;

  // newer pad button word to normalized order, guide and share not mapped
  function automatic logic [15:0] newer_buttons(input logic [15:0] w);
    return {w[7], w[6], w[5], w[4], 1'b0, 1'b0, w[13], w[12],
            w[15], w[14], w[3], w[2], w[11], w[10], w[9], w[8]};
  endfunction

endpackage

`default_nettype wire

/* hdl/gpn_capture.sv */
`default_nettype none

module gpn_capture #(
  parameter int CAPTURE_BYTES = 24
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] report_byte_i,
  input  wire logic       byte_last_i,
  input  wire logic       fire_i,
  output logic            pend_o,
  output logic [7:0]      store_o [CAPTURE_BYTES]
);

  logic [6:0] pos_q, pos_d;
  logic       pend_q, pend_d;
  logic [7:0] store_q [CAPTURE_BYTES];

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      if (byte_last_i) begin
        pos_d = 7'd0;
      end else if (pos_q != gpn_pkg::POS_MAX) begin
        pos_d = pos_q + 7'd1;
      end
    end
  end

  assign pend_d = (accept_i & byte_last_i) | (pend_q & ~fire_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 7'd0;
      pend_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      pend_q <= pend_d;
    end
  end

  for (genvar i = 0; i < CAPTURE_BYTES; i++) begin : g_store
    localparam logic [6:0] IDX = 7'(i);
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (accept_i && pos_q == IDX) begin
          store_q[i] <= report_byte_i;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (accept_i) begin
          if (pos_q == 7'd0) begin
            store_q[i] <= 8'h00;
          end else if (pos_q == IDX) begin
            store_q[i] <= report_byte_i;
          end
        end
      end
    end
  end

  assign pend_o  = pend_q;
  assign store_o = store_q;

endmodule

`default_nettype wire

/* hdl/gpn_decode.sv */
`default_nettype none

module gpn_decode #(
  parameter int CAPTURE_BYTES = 24
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         fire_i,
  input  wire logic [7:0]   store_i [CAPTURE_BYTES],
  input  wire gpn_pkg::cfg_t cfg_i,
  output gpn_pkg::res_t     res_o
);

  localparam int BIT_OF [6] = '{12, 13, 14, 15, 9, 8};

  logic [15:0] bt_q, bt_d;
  logic [7:0]  lt_q, lt_d;
  logic [7:0]  rt_q, rt_d;
  logic [15:0] ax_q [4];
  logic [15:0] ax_d [4];
  logic        link_q, link_d;
  logic        upd;
  logic        reinit;
  logic        conn;
  logic [15:0] w6;
  logic [15:0] w8;

  assign w6 = {store_i[7], store_i[6]};
  assign w8 = {store_i[9], store_i[8]};

  always_comb begin
    bt_d   = bt_q;
    lt_d   = lt_q;
    rt_d   = rt_q;
    ax_d   = ax_q;
    link_d = link_q;
    upd    = 1'b0;
    reinit = 1'b0;
    unique case (cfg_i.controller_type)
      gpn_pkg::TYPE_WIRED: begin
        if (store_i[1] == gpn_pkg::HDR_REPORT) begin
          bt_d = {store_i[3], store_i[2]} & gpn_pkg::WIRED_BTN_MASK;
          lt_d = store_i[4];
          rt_d = store_i[5];
          for (int k = 0; k < 4; k++) begin
            ax_d[k] = {store_i[7 + 2 * k], store_i[6 + 2 * k]};
          end
          upd = 1'b1;
        end
      end
      gpn_pkg::TYPE_WIRELESS: begin
        if (store_i[0][gpn_pkg::WL_LINK_FLAG_BIT]) begin
          link_d = (store_i[1] != 8'h00);
        end
        if (store_i[1][0] && store_i[5] == gpn_pkg::HDR_WIRELESS_PAD) begin
          bt_d = {store_i[7], store_i[6]} & gpn_pkg::WIRELESS_BTN_MASK;
          lt_d = store_i[8];
          rt_d = store_i[9];
          for (int k = 0; k < 4; k++) begin
            ax_d[k] = {store_i[11 + 2 * k], store_i[10 + 2 * k]};
          end
          upd = 1'b1;
        end
      end
      gpn_pkg::TYPE_NEWER: begin
        if (store_i[0] == gpn_pkg::HDR_NEWER_INPUT) begin
          bt_d = gpn_pkg::newer_buttons({store_i[5], store_i[4]});
          bt_d[gpn_pkg::SHARE_BIT] = store_i[22][0];
          lt_d = w6[9:2];
          rt_d = w8[9:2];
          for (int k = 0; k < 4; k++) begin
            ax_d[k] = {store_i[11 + 2 * k], store_i[10 + 2 * k]};
          end
          upd = 1'b1;
        end else if (store_i[0] == gpn_pkg::HDR_NEWER_VKEY) begin
          if (store_i[4] == gpn_pkg::VKEY_DOWN && !bt_q[gpn_pkg::GUIDE_BIT]) begin
            bt_d[gpn_pkg::GUIDE_BIT] = 1'b1;
            upd = 1'b1;
          end else if (store_i[4] == gpn_pkg::VKEY_UP && bt_q[gpn_pkg::GUIDE_BIT]) begin
            bt_d[gpn_pkg::GUIDE_BIT] = 1'b0;
            upd = 1'b1;
          end
        end else if (store_i[0] == gpn_pkg::HDR_NEWER_HELLO) begin
          reinit = 1'b1;
        end
      end
      gpn_pkg::TYPE_ORIGINAL: begin
        if (store_i[1] == gpn_pkg::HDR_REPORT) begin
          bt_d = {8'h00, store_i[2]};
          for (int k = 0; k < 6; k++) begin
            if (store_i[4 + k] > cfg_i.threshold) begin
              bt_d[BIT_OF[k]] = 1'b1;
            end
          end
          lt_d = store_i[10];
          rt_d = store_i[11];
          for (int k = 0; k < 4; k++) begin
            ax_d[k] = {store_i[13 + 2 * k], store_i[12 + 2 * k]};
          end
          upd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cfg_i.controller_type) inside
      gpn_pkg::TYPE_WIRELESS: conn = link_d;
      gpn_pkg::TYPE_WIRED,
      gpn_pkg::TYPE_NEWER,
      gpn_pkg::TYPE_ORIGINAL: conn = 1'b1;
      default:                conn = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bt_q   <= 16'h0000;
      lt_q   <= 8'h00;
      rt_q   <= 8'h00;
      ax_q   <= '{default: 16'h0000};
      link_q <= 1'b0;
    end else if (fire_i) begin
      bt_q   <= bt_d;
      lt_q   <= lt_d;
      rt_q   <= rt_d;
      ax_q   <= ax_d;
      link_q <= link_d;
    end
  end

  always_comb begin
    res_o.buttons        = bt_d;
    res_o.left_trigger   = lt_d;
    res_o.right_trigger  = rt_d;
    res_o.left_x         = ax_d[0];
    res_o.left_y         = ax_d[1];
    res_o.right_x        = ax_d[2];
    res_o.right_y        = ax_d[3];
    res_o.connected      = conn;
    res_o.updated        = upd;
    res_o.reinit_request = reinit;
  end

endmodule

`default_nettype wire

/* hdl/gamepad_report_normalizer.sv */
`default_nettype none

// Gamepad report normalizer: takes one report byte per cycle while in_stall_o is low and, for
// each report, returns one normalized pad state item (buttons, triggers, sticks, link and
// reinit flags) decoded by the configured controller type. A report's last byte is captured
// into the report register file, then decoded into the output register once it is free.
// in_stall_o rises only while a decoded report waits for the output register to drain under
// out_stall_i. controller_type and analog_button_threshold are to be written through the cfg
// port while idle by the user; the block itself does not enforce it.

module gamepad_report_normalizer #(
  parameter int CAPTURE_BYTES = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         report_byte_i,
  input  wire logic               byte_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [15:0]             buttons_o,
  output logic [7:0]              left_trigger_o,
  output logic [7:0]              right_trigger_o,
  output logic signed [15:0]      left_x_o,
  output logic signed [15:0]      left_y_o,
  output logic signed [15:0]      right_x_o,
  output logic signed [15:0]      right_y_o,
  output logic                    connected_o,
  output logic                    updated_o,
  output logic                    reinit_request_o
);

  gpn_pkg::cfg_t cfg_q;
  gpn_pkg::res_t res_d, res_q;
  logic          out_valid_q, out_valid_d;
  logic          pend;
  logic          fire;
  logic          accept;
  logic [7:0]    store [CAPTURE_BYTES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.controller_type <= gpn_pkg::TYPE_UNKNOWN;
      cfg_q.threshold       <= 8'd32;
    end else if (cfg_we_i) begin
      unique case (gpn_pkg::reg_idx_e'(cfg_index_i))
        gpn_pkg::REG_CONTROLLER_TYPE: cfg_q.controller_type <= cfg_data_i[2:0];
        gpn_pkg::REG_THRESHOLD:       cfg_q.threshold       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign fire       = pend & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = pend & ~fire;
  assign accept     = in_valid_i & ~in_stall_o;

  gpn_capture #(
    .CAPTURE_BYTES(CAPTURE_BYTES)
  ) u_capture (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .report_byte_i (report_byte_i),
    .byte_last_i   (byte_last_i),
    .fire_i        (fire),
    .pend_o        (pend),
    .store_o       (store)
  );

  gpn_decode #(
    .CAPTURE_BYTES(CAPTURE_BYTES)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .store_i (store),
    .cfg_i   (cfg_q),
    .res_o   (res_d)
  );

  assign out_valid_d = fire | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign buttons_o        = res_q.buttons;
  assign left_trigger_o   = res_q.left_trigger;
  assign right_trigger_o  = res_q.right_trigger;
  assign left_x_o         = res_q.left_x;
  assign left_y_o         = res_q.left_y;
  assign right_x_o        = res_q.right_x;
  assign right_y_o        = res_q.right_y;
  assign connected_o      = res_q.connected;
  assign updated_o        = res_q.updated;
  assign reinit_request_o = res_q.reinit_request;

endmodule

`default_nettype wire

/* hdl/gpn_checker.sv */
`default_nettype none

module gpn_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               byte_last_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [15:0]        buttons_o,
  input wire logic signed [15:0] left_x_o,
  input wire logic               connected_o,
  input wire logic               updated_o,
  input wire logic               reinit_request_o
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(buttons_o) && $stable(left_x_o))
    else $error("stalled result item changed");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // last byte into an empty output leads to a valid result item
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i && !in_stall_o && byte_last_i |-> ##2 out_valid_o)
    else $error("result item missing after last byte");

  // announce never updates pad state and only comes from a connected pad
  a_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reinit_request_o |-> !updated_o && connected_o)
    else $error("reinit item with update or without link");

endmodule

bind gamepad_report_normalizer gpn_checker u_gpn_checker (.*);

`default_nettype wire
